// File: rtl/hnbw_pkg.sv
// Shared types and mixing constants for the hashed node bit window generator.
`timescale 1ns / 1ps

package hnbw_pkg;

  typedef logic [63:0] word_t;

  // splitmix64 finalizer constants
  localparam word_t GOLDEN  = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_C1  = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_C2  = 64'h94d049bb133111eb;

  // seed formation constants
  localparam word_t SEED_BASE  = 64'h747265654e6f6465;
  localparam word_t SEED_LEVEL = 64'hd6e8feb86659fd93;
  localparam word_t SEED_INDEX = 64'ha5a3564e27f8862f;

  // pipeline depths
  localparam int MUL_LAT  = 2;
  localparam int MIX_LAT  = 2 * MUL_LAT + 3;
  localparam int SEED_LAT = MUL_LAT + 1;

  // window geometry: width is at most 63, chunk number is 8 bits
  localparam int WIDTH_W = 6;
  localparam int CHUNK_W = 8;
  localparam int START_W = WIDTH_W + CHUNK_W;
  localparam int VALUE_W = 63;

  // floor(log2(8192)) for the reset modulus
  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd13;

endpackage

// File: rtl/hnbw_mul64.sv
// Two-stage 64x64 multiplier keeping the low 64 bits of the product.
`timescale 1ns / 1ps

module hnbw_mul64 (
  input  logic           clk,
  input  logic           en,
  input  hnbw_pkg::word_t a_i,
  input  hnbw_pkg::word_t b_i,
  output hnbw_pkg::word_t p_o
);

  logic [63:0] ll_r;
  logic [31:0] lh_r;
  logic [31:0] hl_r;
  hnbw_pkg::word_t p_r;

  logic [63:0] lh_full;
  logic [63:0] hl_full;

  // cross products only matter in their low halves
  assign lh_full = a_i[31:0] * b_i[63:32];
  assign hl_full = a_i[63:32] * b_i[31:0];

  // stage 1: 32x32 partial products
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= a_i[31:0] * b_i[31:0];
      lh_r <= lh_full[31:0];
      hl_r <= hl_full[31:0];
    end
  end

  // stage 2: fold partials into the low word
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ll_r + {lh_r + hl_r, 32'd0};
    end
  end

  assign p_o = p_r;

endmodule

// File: rtl/hnbw_mix.sv
// One pipelined splitmix64 round: add offset, xor-shift, multiply, twice, xor-shift.
`timescale 1ns / 1ps

module hnbw_mix (
  input  logic            clk,
  input  logic            en,
  input  hnbw_pkg::word_t state_i,
  input  hnbw_pkg::word_t add_k,
  output hnbw_pkg::word_t word_o
);

  hnbw_pkg::word_t v;
  hnbw_pkg::word_t x1_r;
  hnbw_pkg::word_t pa;
  hnbw_pkg::word_t x2_r;
  hnbw_pkg::word_t pb;
  hnbw_pkg::word_t word_r;

  // add golden ratio plus word number, then first xor-shift
  assign v = state_i + add_k;

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r <= v ^ (v >> 30);
    end
  end

  hnbw_mul64 u_mul_a (
    .clk (clk),
    .en  (en),
    .a_i (x1_r),
    .b_i (hnbw_pkg::MIX_C1),
    .p_o (pa)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r <= pa ^ (pa >> 27);
    end
  end

  hnbw_mul64 u_mul_b (
    .clk (clk),
    .en  (en),
    .a_i (x2_r),
    .b_i (hnbw_pkg::MIX_C2),
    .p_o (pb)
  );

  // final xor-shift
  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= pb ^ (pb >> 31);
    end
  end

  assign word_o = word_r;

endmodule

// File: rtl/hnbw_extract.sv
// Two-stage bit window extraction from the node value, ending in the output register.
`timescale 1ns / 1ps

module hnbw_extract #(
  parameter int NODE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 vld_i,
  input  logic [hnbw_pkg::START_W-1:0]         start_i,
  input  logic [hnbw_pkg::WIDTH_W-1:0]         width_i,
  input  logic [NODE_BITS-1:0]                 node_i,
  output logic                                 vld_o,
  output logic [hnbw_pkg::VALUE_W-1:0]         value_o
);

  localparam int SHW = $clog2(NODE_BITS);

  logic                          vld1_r;
  logic                          vld2_r;
  logic [63:0]                   win_r;
  logic [hnbw_pkg::VALUE_W-1:0]  value_r;
  logic [63:0]                   mask;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
    end
  end

  // stage 1: shift window down, nothing left when it starts past the end
  always_ff @(posedge clk) begin
    if (en) begin
      if (start_i >= hnbw_pkg::START_W'(NODE_BITS)) begin
        win_r <= '0;
      end else begin
        win_r <= 64'(node_i >> start_i[SHW-1:0]);
      end
    end
  end

  // stage 2: keep only width bits
  assign mask = (64'd1 << width_i) - 64'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= win_r[hnbw_pkg::VALUE_W-1:0] & mask[hnbw_pkg::VALUE_W-1:0];
    end
  end

  assign vld_o   = vld2_r;
  assign value_o = value_r;

endmodule

// File: rtl/hashed_node_bit_window_top.sv
// Top level of the hashed node bit window generator: seed, mix rounds, extraction.
`timescale 1ns / 1ps

// Takes one transaction per clock while the pipeline is not held and returns one
// chunk_value per transaction, in order, after the seed stage, the mix rounds and
// the extraction stages. The depth comes from the chained splitmix64 rounds: each 64-bit
// multiply is split into 32-bit partial products over two stages, and every round
// holds two of them. The whole pipeline holds while a result waits under out_stall,
// and in_stall follows that hold. A cfg_wr_en write sets the modulus; its floor log2
// is stored as the window width (the reset modulus 8192 gives a width of 13).
// Write the modulus only with no transaction in flight.
module hashed_node_bit_window_top #(
  parameter int NODE_BITS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [5:0]                           in_tree_level,
  input  logic [62:0]                          in_node_index,
  input  logic [hnbw_pkg::CHUNK_W-1:0]         in_chunk_number,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [hnbw_pkg::VALUE_W-1:0]         out_chunk_value,
  input  logic                                 cfg_wr_en,
  input  logic [63:0]                          cfg_wr_data
);

  localparam int NODE_WORDS = (NODE_BITS + 63) / 64;
  localparam int LINE_LEN   = hnbw_pkg::SEED_LAT + hnbw_pkg::MIX_LAT * NODE_WORDS;

  // six halving steps give floor(log2 t); 0 and 1 both give 0
  function automatic logic [hnbw_pkg::WIDTH_W-1:0] floor_log2(input logic [63:0] t);
    logic [63:0]                  v;
    logic [hnbw_pkg::WIDTH_W-1:0] w;
    v = t;
    w = '0;
    if (v[63:32] != '0) begin
      w[5] = 1'b1;
      v    = v >> 32;
    end
    if (v[31:16] != '0) begin
      w[4] = 1'b1;
      v    = v >> 16;
    end
    if (v[15:8] != '0) begin
      w[3] = 1'b1;
      v    = v >> 8;
    end
    if (v[7:4] != '0) begin
      w[2] = 1'b1;
      v    = v >> 4;
    end
    if (v[3:2] != '0) begin
      w[1] = 1'b1;
      v    = v >> 2;
    end
    if (v[1]) begin
      w[0] = 1'b1;
    end
    return w;
  endfunction

  logic                             en;
  logic [hnbw_pkg::WIDTH_W-1:0]     width_r;
  logic [hnbw_pkg::START_W-1:0]     start;
  logic [LINE_LEN-1:0]              vld_line_r;
  logic [hnbw_pkg::START_W-1:0]     start_line_r [LINE_LEN];
  hnbw_pkg::word_t                  level_prod;
  hnbw_pkg::word_t                  index_prod;
  hnbw_pkg::word_t                  seed_r;
  hnbw_pkg::word_t                  round_out [NODE_WORDS];
  hnbw_pkg::word_t                  word_dly [NODE_WORDS];
  logic [NODE_WORDS*64-1:0]         node_full;

  // pipeline advances unless a finished result is held
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // window width from the modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= hnbw_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      width_r <= floor_log2(cfg_wr_data);
    end
  end

  // window start bit, carried alongside the hash; full 14-bit product
  assign start = hnbw_pkg::START_W'(width_r) * hnbw_pkg::START_W'(in_chunk_number);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_line_r <= '0;
    end else if (en) begin
      vld_line_r <= {vld_line_r[LINE_LEN-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      start_line_r[0] <= start;
      for (int k = 1; k < LINE_LEN; k++) begin
        start_line_r[k] <= start_line_r[k-1];
      end
    end
  end

  // seed: base xor level and index products
  hnbw_mul64 u_mul_level (
    .clk (clk),
    .en  (en),
    .a_i ({58'd0, in_tree_level}),
    .b_i (hnbw_pkg::SEED_LEVEL),
    .p_o (level_prod)
  );

  hnbw_mul64 u_mul_index (
    .clk (clk),
    .en  (en),
    .a_i ({1'b0, in_node_index}),
    .b_i (hnbw_pkg::SEED_INDEX),
    .p_o (index_prod)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      seed_r <= hnbw_pkg::SEED_BASE ^ level_prod ^ index_prod;
    end
  end

  // chained mix rounds; earlier words are delayed to line up with the last one
  for (genvar r = 0; r < NODE_WORDS; r++) begin : g_round
    localparam hnbw_pkg::word_t ADD_K = hnbw_pkg::GOLDEN + hnbw_pkg::word_t'(r);
    localparam int DLY = hnbw_pkg::MIX_LAT * (NODE_WORDS - 1 - r);

    hnbw_pkg::word_t round_in;

    if (r == 0) begin : g_first
      assign round_in = seed_r;
    end else begin : g_next
      assign round_in = round_out[r-1];
    end

    hnbw_mix u_mix (
      .clk     (clk),
      .en      (en),
      .state_i (round_in),
      .add_k   (ADD_K),
      .word_o  (round_out[r])
    );

    if (DLY == 0) begin : g_nodly
      assign word_dly[r] = round_out[r];
    end else begin : g_dly
      hnbw_pkg::word_t dly_r [DLY];
      always_ff @(posedge clk) begin
        if (en) begin
          dly_r[0] <= round_out[r];
          for (int k = 1; k < DLY; k++) begin
            dly_r[k] <= dly_r[k-1];
          end
        end
      end
      assign word_dly[r] = dly_r[DLY-1];
    end

    // little-endian placement, word 0 lowest
    assign node_full[r*64 +: 64] = word_dly[r];
  end

  hnbw_extract #(
    .NODE_BITS (NODE_BITS)
  ) u_extract (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (vld_line_r[LINE_LEN-1]),
    .start_i (start_line_r[LINE_LEN-1]),
    .width_i (width_r),
    .node_i  (node_full[NODE_BITS-1:0]),
    .vld_o   (out_valid),
    .value_o (out_chunk_value)
  );

  // a held result freezes the items behind it
  a_hold_freezes_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(vld_line_r))
    else $error("pipeline moved while result was held");

  // zero width windows give zero
  a_zero_width: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && width_r == '0) |-> (out_chunk_value == '0))
    else $error("nonzero result for zero window width");

  // no bits above the window width
  a_width_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((64'(out_chunk_value) >> width_r) == 64'd0))
    else $error("result has bits above the window width");

  // reset leaves nothing in flight
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && vld_line_r == '0))
    else $error("items survived reset");

endmodule

// File: bench/tb_hashed_node_bit_window_top.sv
// Self-checking testbench for hashed_node_bit_window_top: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_hashed_node_bit_window_top;

  localparam int NODE_BITS = 256;
  localparam int PIPE_LAT = 3 + 7 * ((NODE_BITS + 63) / 64) + 2;
  localparam int CYCLE_LIMIT = 400000;
  localparam hnbw_pkg::word_t RESET_MODULUS = 64'd8192;
  localparam hnbw_pkg::word_t ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam hnbw_pkg::word_t TOP_BIT = 64'h8000_0000_0000_0000;
  localparam logic [62:0] MAX_INDEX = 63'h7FFF_FFFF_FFFF_FFFF;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 119;

  // receiver stall behaviors
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SQUARE
  } stall_mode_t;

  // one directed transaction; value is used only when known is set
  typedef struct packed {
    hnbw_pkg::word_t  modulus;
    logic [5:0]       level;
    logic [62:0]      index;
    logic [7:0]       chunk;
    logic             known;
    logic [hnbw_pkg::VALUE_W-1:0] value;
  } chunk_case_t;

  localparam int NUM_CASES = 22;
  localparam chunk_case_t DIRECTED_CASES [0:NUM_CASES-1] = '{
    // reset modulus, 13-bit windows
    '{RESET_MODULUS, 6'd0,  63'd0,     8'd0,   1'b0, 63'd0},
    '{RESET_MODULUS, 6'd63, MAX_INDEX, 8'd0,   1'b0, 63'd0},
    '{RESET_MODULUS, 6'd1,  63'd1,     8'd4,   1'b0, 63'd0},  // crosses word 0/1
    '{RESET_MODULUS, 6'd0,  63'd0,     8'd19,  1'b0, 63'd0},  // runs off the end
    '{RESET_MODULUS, 6'd5,  63'd123,   8'd20,  1'b1, 63'd0},  // wholly past the end
    '{RESET_MODULUS, 6'd63, MAX_INDEX, 8'd255, 1'b1, 63'd0},
    // smallest modulus, 1-bit windows
    '{64'd2, 6'd0,  63'd0,     8'd0,   1'b0, 63'd0},
    '{64'd2, 6'd63, MAX_INDEX, 8'd255, 1'b0, 63'd0},          // top bit of the node
    '{64'd2, 6'd7,  63'd5,     8'd128, 1'b0, 63'd0},
    '{64'd2, 6'd42, 63'd1,     8'd64,  1'b0, 63'd0},
    // largest modulus and top bit (63-bit windows), then 62-bit and 1-bit windows
    '{ALL_ONES, 6'd0,  63'd0,     8'd0,   1'b0, 63'd0},
    '{ALL_ONES, 6'd63, MAX_INDEX, 8'd1,   1'b0, 63'd0},
    '{ALL_ONES, 6'd9,  63'd77,    8'd4,   1'b0, 63'd0},       // only four bits left
    '{ALL_ONES, 6'd9,  63'd77,    8'd5,   1'b1, 63'd0},
    '{ALL_ONES, 6'd0,  63'd0,     8'd255, 1'b1, 63'd0},
    '{TOP_BIT, 6'd33, 63'h2AAA_AAAA_AAAA_AAAA, 8'd2, 1'b0, 63'd0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 6'd21, 63'h5555_5555_5555_5555, 8'd3, 1'b0, 63'd0},
    '{64'd3, 6'd1, 63'd0, 8'd200, 1'b0, 63'd0},
    // 32-bit windows, last full word then past the end
    '{64'h1_0000_0000, 6'd60, 63'h0123_4567_89AB_CDEF, 8'd7, 1'b0, 63'd0},
    '{64'h1_0000_0000, 6'd60, 63'h0123_4567_89AB_CDEF, 8'd8, 1'b1, 63'd0},
    // 12-bit windows, straddling the end then past the end
    '{64'd8191, 6'd2, 63'd99, 8'd21, 1'b0, 63'd0},
    '{64'd8191, 6'd2, 63'd99, 8'd22, 1'b1, 63'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [5:0] in_tree_level = '0;
  logic [62:0] in_node_index = '0;
  logic [hnbw_pkg::CHUNK_W-1:0] in_chunk_number = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [hnbw_pkg::VALUE_W-1:0] out_chunk_value;
  logic cfg_wr_en = 1'b0;
  logic [63:0] cfg_wr_data = '0;

  logic [hnbw_pkg::VALUE_W-1:0] pending_windows [$];
  hnbw_pkg::word_t modulus_now;
  int errors = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int square_period = 4;
  stall_mode_t stall_mode = STALL_NONE;

  hashed_node_bit_window_top #(
    .NODE_BITS(NODE_BITS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_tree_level(in_tree_level),
    .in_node_index(in_node_index),
    .in_chunk_number(in_chunk_number),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_chunk_value(out_chunk_value),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // splitmix64 finalizer
  function automatic hnbw_pkg::word_t mix_word(hnbw_pkg::word_t v);
    v = v + hnbw_pkg::GOLDEN;
    v = (v ^ (v >> 30)) * hnbw_pkg::MIX_C1;
    v = (v ^ (v >> 27)) * hnbw_pkg::MIX_C2;
    return v ^ (v >> 31);
  endfunction

  // floor(log2 t), zero below two
  function automatic int window_width(hnbw_pkg::word_t t);
    int w;
    w = 0;
    for (int b = 1; b < 64; b++) begin
      if (t[b]) w = b;
    end
    return w;
  endfunction

  // expected chunk_value for one transaction under modulus t
  function automatic logic [hnbw_pkg::VALUE_W-1:0] predict_window(logic [5:0] lvl,
                                                                  logic [62:0] idx,
                                                                  logic [7:0] chunk,
                                                                  hnbw_pkg::word_t t);
    hnbw_pkg::word_t acc;
    logic [NODE_BITS-1:0] node;
    int width;
    int first;
    logic [hnbw_pkg::VALUE_W-1:0] win;
    acc = hnbw_pkg::SEED_BASE ^ (hnbw_pkg::word_t'(lvl) * hnbw_pkg::SEED_LEVEL)
          ^ (hnbw_pkg::word_t'(idx) * hnbw_pkg::SEED_INDEX);
    for (int w = 0; w < NODE_BITS / 64; w++) begin
      acc = mix_word(acc + hnbw_pkg::word_t'(w));
      node[w*64 +: 64] = acc;
    end
    width = window_width(t);
    first = width * int'(chunk);
    win = '0;
    for (int b = 0; b < width; b++) begin
      if (first + b < NODE_BITS) win[b] = node[first + b];
    end
    return win;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL hashed_node_bit_window_top");
      $finish;
    end
  end

  // receiver stall pattern, picking a new random mode after each random-length run
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(32, 256);
      square_period = $urandom_range(1, 12);
    end
    stall_left = stall_left - 1;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 2) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count / square_period) % 2) == 1;
    endcase
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual %h",
                 $time, out_chunk_value);
        errors++;
      end else begin
        if (out_chunk_value !== pending_windows[0]) begin
          $display("%0t: chunk_value mismatch, expected %h, actual %h",
                   $time, pending_windows[0], out_chunk_value);
          errors++;
        end
        void'(pending_windows.pop_front());
      end
    end
  end

  // drive one transaction from a falling edge; returns at the falling edge after acceptance
  task automatic issue_chunk(logic [5:0] lvl, logic [62:0] idx, logic [7:0] chunk,
                             logic known, logic [hnbw_pkg::VALUE_W-1:0] value);
    in_valid <= 1'b1;
    in_tree_level <= lvl;
    in_node_index <= idx;
    in_chunk_number <= chunk;
    do @(posedge clk); while (in_stall);
    pending_windows.insert(pending_windows.size(),
                           known ? value : predict_window(lvl, idx, chunk, modulus_now));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_windows.size() != 0) @(negedge clk);
  endtask

  // modulus write with the pipeline empty
  task automatic load_modulus(hnbw_pkg::word_t t);
    in_valid <= 1'b0;
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    modulus_now = t;
  endtask

  initial begin
    int burst_left;
    int gap;
    int span;
    int width;
    hnbw_pkg::word_t t;
    logic [5:0] lvl;
    logic [62:0] idx;
    logic [7:0] chunk;

    modulus_now = RESET_MODULUS;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, modulus changes only where a row asks for it
    for (int i = 0; i < NUM_CASES; i++) begin
      if (DIRECTED_CASES[i].modulus != modulus_now) load_modulus(DIRECTED_CASES[i].modulus);
      issue_chunk(DIRECTED_CASES[i].level, DIRECTED_CASES[i].index, DIRECTED_CASES[i].chunk,
                  DIRECTED_CASES[i].known, DIRECTED_CASES[i].value);
    end

    // random phases, each under its own modulus
    burst_left = 1;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0: t = 64'd2;
        1: t = ALL_ONES;
        2: t = TOP_BIT;
        default: begin
          width = $urandom_range(1, 63);
          t = (64'd1 << width) | ({$urandom, $urandom} & ((64'd1 << width) - 64'd1));
        end
      endcase
      load_modulus(t);
      width = window_width(modulus_now);
      span = (NODE_BITS + width - 1) / width;
      if (span > 255) span = 255;

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        lvl = 6'($urandom);
        case ($urandom_range(0, 7))
          0: idx = '0;
          1: idx = MAX_INDEX;
          default: idx = 63'({$urandom, $urandom});
        endcase
        // mostly windows inside the node, some anywhere
        if ($urandom_range(0, 3) == 0) chunk = 8'($urandom);
        else chunk = 8'($urandom_range(0, span));
        issue_chunk(lvl, idx, chunk, 1'b0, '0);

        // sender bursts with random gaps
        burst_left--;
        gap = 0;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 12);
        end
        if (phase == 3 && k == PHASE_ITEMS / 2) begin
          // hold off until the pipeline is empty
          in_valid <= 1'b0;
          wait_drained();
        end else if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (2 * PIPE_LAT) @(posedge clk);
    if (pending_windows.size() != 0) begin
      $display("%0t: %0d transactions never returned", $time, pending_windows.size());
      errors++;
    end
    if (errors == 0) begin
      $display("PASS hashed_node_bit_window_top");
    end else begin
      $display("FAIL hashed_node_bit_window_top");
    end
    $finish;
  end

endmodule
